// ===== sv/rarst_pkg.sv =====
`timescale 1ns / 1ps

package rarst_pkg;

    // Default number of positions covered by the store.
    localparam int RAS_SIZE = 1024;

    localparam int CFG_W   = 11;
    localparam int FUNC_W  = 2;
    localparam int POS_W   = 11;
    localparam int DELTA_W = 32;
    localparam int SUM_W   = 64;

    localparam logic [CFG_W-1:0] ELEM_COUNT_RST = 11'd1024;

    typedef enum logic [FUNC_W-1:0] {
        FN_ADD   = 2'd0,
        FN_QUERY = 2'd1,
        FN_CLEAR = 2'd2,
        FN_NONE  = 2'd3
    } t_func;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic upd_lo;
        logic upd_hi;
        logic rd;
        logic upd_wr;
        logic qry_hi;
        logic qry_lo;
        logic qry_acc;
        logic mul1;
        logic mul2;
        logic comb;
        logic comb_sub;
        logic res_clr;
        logic clr_start;
        logic clr_step;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_func func;
        logic  empty;
        logic  idx_over;
        logic  idx_zero;
        logic  idx_last;
        logic  hi_end;
        logic  lo_one;
    } t_status;

endpackage

// ===== sv/rarst_datapath.sv =====
`timescale 1ns / 1ps

module rarst_datapath import rarst_pkg::*; #(
    parameter int SIZE = RAS_SIZE
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CFG_W-1:0]   i_cfg_wdata,
    input  logic [FUNC_W-1:0]  i_func,
    input  logic [POS_W-1:0]   i_range_low,
    input  logic [POS_W-1:0]   i_range_high,
    input  logic [DELTA_W-1:0] i_delta,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    output logic [SUM_W-1:0]   o_range_sum
);

    localparam int AW    = $clog2(SIZE + 1);
    localparam int IW    = AW + 1;
    localparam int LW    = (CFG_W > IW) ? CFG_W : IW;
    localparam int DEPTH = 1 << AW;

    // Each word holds the two Fenwick entries of one index: {coefficient, offset}.
    logic [2*SUM_W-1:0] mem [DEPTH];

    logic [CFG_W-1:0]   r_elem_count;
    t_func              r_func;
    logic               r_empty;
    logic [IW-1:0]      r_lo, r_hi, r_idx, r_pt;
    logic [DELTA_W-1:0] r_d;
    logic [SUM_W-1:0]   r_v1, r_v2, r_a1, r_a2, r_p_lo, r_p_hi, r_res;
    logic [2*SUM_W-1:0] r_rd;

    logic [LW-1:0]      ec_w, size_w, lim, lo_w, hi_raw, hi_w;
    logic               empty;
    logic [IW-1:0]      lowbit;
    logic [SUM_W-1:0]   d_ext, m_lo, m_hi, pre_sum;
    logic [2*SUM_W-1:0] wdata;
    logic               wen;

    always_comb begin
        ec_w   = LW'(r_elem_count);
        size_w = LW'(SIZE);
        lim    = (ec_w > size_w) ? size_w : ec_w;
        lo_w   = (i_range_low == '0) ? LW'(1) : LW'(i_range_low);
        hi_raw = LW'(i_range_high);
        hi_w   = (hi_raw > lim) ? lim : hi_raw;
        empty  = (lim == '0) || (lo_w > hi_w);
    end

    assign d_ext   = {{(SUM_W-DELTA_W){r_d[DELTA_W-1]}}, r_d};
    assign lowbit  = r_idx & (~r_idx + IW'(1));
    assign m_lo    = SUM_W'($signed(r_d) * $signed({1'b0, r_lo - IW'(1)}));
    assign m_hi    = SUM_W'($signed(r_d) * $signed({1'b0, r_hi}));
    assign pre_sum = r_p_lo + {r_p_hi[SUM_W/2-1:0], {(SUM_W/2){1'b0}}} - r_a2;

    assign wen   = i_cmd.upd_wr | i_cmd.clr_step;
    assign wdata = i_cmd.clr_step ? '0
                 : {r_rd[2*SUM_W-1:SUM_W] + r_v1, r_rd[SUM_W-1:0] + r_v2};

    always_ff @(posedge i_clk) begin
        if (wen) begin
            mem[r_idx[AW-1:0]] <= wdata;
        end
        if (i_cmd.rd) begin
            r_rd <= mem[r_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elem_count <= ELEM_COUNT_RST;
        end else if (i_cfg_we) begin
            r_elem_count <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= t_func'(i_func);
            r_empty <= empty;
            r_lo    <= lo_w[IW-1:0];
            r_hi    <= hi_w[IW-1:0];
            r_d     <= i_delta;
        end
        if (i_cmd.upd_lo) begin
            r_idx <= r_lo;
            r_v1  <= d_ext;
            r_v2  <= m_lo;
        end
        if (i_cmd.upd_hi) begin
            r_idx <= r_hi + IW'(1);
            r_v1  <= -d_ext;
            r_v2  <= -m_hi;
        end
        if (i_cmd.upd_wr) begin
            r_idx <= r_idx + lowbit;
        end
        if (i_cmd.qry_hi) begin
            r_idx <= r_hi;
            r_pt  <= r_hi;
            r_a1  <= '0;
            r_a2  <= '0;
        end
        if (i_cmd.qry_lo) begin
            r_idx <= r_lo - IW'(1);
            r_pt  <= r_lo - IW'(1);
            r_a1  <= '0;
            r_a2  <= '0;
        end
        if (i_cmd.qry_acc) begin
            r_a1  <= r_a1 + r_rd[2*SUM_W-1:SUM_W];
            r_a2  <= r_a2 + r_rd[SUM_W-1:0];
            r_idx <= r_idx - lowbit;
        end
        if (i_cmd.mul1) begin
            r_p_lo <= {{(SUM_W/2){1'b0}}, r_a1[SUM_W/2-1:0]}
                    * {{(SUM_W-IW){1'b0}}, r_pt};
        end
        if (i_cmd.mul2) begin
            r_p_hi <= {{(SUM_W/2){1'b0}}, r_a1[SUM_W-1:SUM_W/2]}
                    * {{(SUM_W-IW){1'b0}}, r_pt};
        end
        if (i_cmd.res_clr) begin
            r_res <= '0;
        end
        if (i_cmd.comb) begin
            r_res <= i_cmd.comb_sub ? (r_res - pre_sum) : (r_res + pre_sum);
        end
        if (i_cmd.clr_start) begin
            r_idx <= IW'(1);
        end
        if (i_cmd.clr_step) begin
            r_idx <= r_idx + IW'(1);
        end
    end

    assign o_status.func     = r_func;
    assign o_status.empty    = r_empty;
    assign o_status.idx_over = r_idx > IW'(SIZE);
    assign o_status.idx_zero = r_idx == '0;
    assign o_status.idx_last = r_idx == IW'(SIZE);
    assign o_status.hi_end   = r_hi == IW'(SIZE);
    assign o_status.lo_one   = r_lo == IW'(1);
    assign o_range_sum       = r_res;

endmodule

// ===== sv/rarst_ctrl.sv =====
`timescale 1ns / 1ps

module rarst_ctrl import rarst_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    busy,
    output logic    o_valid
);

    typedef enum logic [11:0] {
        S_CINIT = 12'b0000_0000_0001,
        S_CLR   = 12'b0000_0000_0010,
        S_IDLE  = 12'b0000_0000_0100,
        S_DISP  = 12'b0000_0000_1000,
        S_U_RD  = 12'b0000_0001_0000,
        S_U_WR  = 12'b0000_0010_0000,
        S_Q_RD  = 12'b0000_0100_0000,
        S_Q_ACC = 12'b0000_1000_0000,
        S_M1    = 12'b0001_0000_0000,
        S_M2    = 12'b0010_0000_0000,
        S_M3    = 12'b0100_0000_0000,
        S_OUT   = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_second, n_second;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CINIT;
            r_second <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_second <= n_second;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_second = r_second;
        o_cmd    = '0;
        unique case (r_state)
            S_CINIT: begin
                o_cmd.clr_start = 1'b1;
                n_state         = S_CLR;
            end
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.idx_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                unique case (i_status.func)
                    FN_ADD: begin
                        if (i_status.empty) begin
                            n_state = S_IDLE;
                        end else begin
                            o_cmd.upd_lo = 1'b1;
                            n_second     = 1'b0;
                            n_state      = S_U_RD;
                        end
                    end
                    FN_QUERY: begin
                        o_cmd.res_clr = 1'b1;
                        if (i_status.empty) begin
                            n_state = S_OUT;
                        end else begin
                            o_cmd.qry_hi = 1'b1;
                            n_second     = 1'b0;
                            n_state      = S_Q_RD;
                        end
                    end
                    FN_CLEAR: begin
                        o_cmd.clr_start = 1'b1;
                        n_state         = S_CLR;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_U_RD: begin
                if (i_status.idx_over) begin
                    if (!r_second && !i_status.hi_end) begin
                        o_cmd.upd_hi = 1'b1;
                        n_second     = 1'b1;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_U_WR;
                end
            end
            S_U_WR: begin
                o_cmd.upd_wr = 1'b1;
                n_state      = S_U_RD;
            end
            S_Q_RD: begin
                if (i_status.idx_zero) begin
                    n_state = S_M1;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_Q_ACC;
                end
            end
            S_Q_ACC: begin
                o_cmd.qry_acc = 1'b1;
                n_state       = S_Q_RD;
            end
            S_M1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = S_M2;
            end
            S_M2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = S_M3;
            end
            S_M3: begin
                o_cmd.comb     = 1'b1;
                o_cmd.comb_sub = r_second;
                if (!r_second && !i_status.lo_one) begin
                    o_cmd.qry_lo = 1'b1;
                    n_second     = 1'b1;
                    n_state      = S_Q_RD;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy    = r_state != S_IDLE;
    assign o_valid = r_state == S_OUT;

endmodule

// ===== sv/range_add_range_sum_tree_top.sv =====
`timescale 1ns / 1ps

// Range-add / range-sum store over positions 1..SIZE, wrapping modulo 2^64.
// An item is accepted on a rising edge with start high and busy low. Its
// func selects a range add of delta over [low, high], a range sum query or
// a clear of the whole store; ranges are cut to 1..min(elem_count, SIZE) and an empty
// range adds nothing and sums to zero. A query returns one beat on
// o_range_sum, marked by o_valid for exactly one cycle; the receiver cannot
// stall, so the beat must be taken when it appears.
// The store is held as two Fenwick trees packed into one memory word per
// index, with one read and one write port. Each index visited takes a
// registered read, then an update or accumulate step. An add walks up the
// tree from low and, unless high is SIZE, again from high+1; a query makes
// up to two prefix walks, at high and (unless low is 1) at low-1, each
// followed by a two-step split 64-bit multiply. A clear runs over the whole
// store, one memory word a cycle. After reset the same clearing pass runs
// with busy high; elem_count returns to 1024 and may be written at any
// time the block is idle, by i_cfg_we with i_cfg_wdata.
module range_add_range_sum_tree_top import rarst_pkg::*; #(
    parameter int SIZE = RAS_SIZE
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CFG_W-1:0]   i_cfg_wdata,
    input  logic               start,
    output logic               busy,
    input  logic [FUNC_W-1:0]  i_func,
    input  logic [POS_W-1:0]   i_range_low,
    input  logic [POS_W-1:0]   i_range_high,
    input  logic [DELTA_W-1:0] i_delta,
    output logic               o_valid,
    output logic [SUM_W-1:0]   o_range_sum
);

    t_cmd    cmd;
    t_status status;

    // The controller sequences the tree walks; the datapath owns the memory.
    rarst_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy),
        .o_valid  (o_valid)
    );

    rarst_datapath #(
        .SIZE (SIZE)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_func       (i_func),
        .i_range_low  (i_range_low),
        .i_range_high (i_range_high),
        .i_delta      (i_delta),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_range_sum  (o_range_sum)
    );

endmodule
